>>> rtl/mtl_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mtl_pkg
// Shared types, character codes and the result-list helper for the markup
// to text line converter.
// ----------------------------------------------------------------------------
package mtl_pkg;

  localparam logic [2:0] TAG_NAME_MAX = 3'd6;
  localparam logic [3:0] ENTITY_MAX   = 4'd14;

  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_END  = 1'b1;

  localparam logic [1:0] STYLE_NORMAL = 2'd0;
  localparam logic [1:0] STYLE_TITLE  = 2'd1;
  localparam logic [1:0] STYLE_LINK   = 2'd2;

  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_QUOT  = 8'h22;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_APOS  = 8'h27;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_CASE  = 8'd32;

  typedef enum logic [2:0] {
    KIND_CHAR  = 3'd0,
    KIND_EOL   = 3'd1,
    KIND_BLANK = 3'd2,
    KIND_EMPTY = 3'd3,
    KIND_END   = 3'd4
  } kind_e;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] ch;
    logic [1:0] style;
    logic       last;
  } res_t;

  // Up to three results per transaction, n gives how many are filled
  typedef struct packed {
    res_t [2:0] r;
    logic [1:0] n;
  } res_list_t;

  function automatic res_list_t res_push(res_list_t l, kind_e k, logic [7:0] ch,
                                         logic [1:0] st);
    res_list_t o;
    o = l;
    if (l.n != 2'd3) begin
      if (l.n != 2'd0) begin
        o.r[l.n - 2'd1].last = 1'b0;
      end
      o.r[l.n].kind  = k;
      o.r[l.n].ch    = ch;
      o.r[l.n].style = st;
      o.r[l.n].last  = 1'b1;
      o.n            = l.n + 2'd1;
    end
    return o;
  endfunction

endpackage
`default_nettype wire

>>> rtl/mtl_step.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mtl_step
// Scanner state and the single-pass decode of one transaction into its list
// of results; state advances when the result list is taken.
// ----------------------------------------------------------------------------
module mtl_step import mtl_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       en_i,
  input  wire logic       op_i,
  input  wire logic [7:0] data_byte_i,
  output res_list_t       res_o
);

  localparam logic [2:0] MODE_TEXT      = 3'd0;
  localparam logic [2:0] MODE_TAG_START = 3'd1;
  localparam logic [2:0] MODE_TAG_NAME  = 3'd2;
  localparam logic [2:0] MODE_TAG_SKIP  = 3'd3;
  localparam logic [2:0] MODE_ENTITY    = 3'd4;

  logic [2:0]      mode_q, mode_d;
  logic            clos_q, clos_d;
  logic [7:0]      first_q, first_d;
  logic [2:0]      tcnt_q, tcnt_d;
  logic [1:0]      sty_q, sty_d;
  logic            lht_q, lht_d;
  logic            any_q, any_d;
  logic [3:0][7:0] ent_q, ent_d;
  logic [3:0]      ecnt_q, ecnt_d;

  always_comb begin
    res_list_t  l;
    logic       do_ftag;
    logic       do_fent;
    logic       do_text;
    logic       do_start;
    logic       ehit;
    logic [7:0] ech;
    logic [7:0] t;

    mode_d   = mode_q;
    clos_d   = clos_q;
    first_d  = first_q;
    tcnt_d   = tcnt_q;
    sty_d    = sty_q;
    lht_d    = lht_q;
    any_d    = any_q;
    ent_d    = ent_q;
    ecnt_d   = ecnt_q;
    l        = '0;
    do_ftag  = 1'b0;
    do_fent  = 1'b0;
    do_text  = 1'b0;
    do_start = 1'b0;
    ehit     = 1'b0;
    ech      = 8'h00;
    t        = 8'h00;

    if (op_i == OP_END) begin
      if (mode_q == MODE_TAG_START || mode_q == MODE_TAG_NAME ||
          mode_q == MODE_TAG_SKIP) begin
        do_ftag = 1'b1;
      end else if (mode_q == MODE_ENTITY) begin
        do_fent = 1'b1;
      end
    end else begin
      unique case (mode_q) inside
        MODE_TAG_START, MODE_TAG_NAME: begin
          if (mode_q == MODE_TAG_START && data_byte_i == CH_SLASH) begin
            clos_d = 1'b1;
            mode_d = MODE_TAG_NAME;
          end else if (data_byte_i == CH_GT) begin
            do_ftag = 1'b1;
          end else if (data_byte_i == CH_SPACE || data_byte_i == CH_LF) begin
            mode_d = MODE_TAG_SKIP;
          end else begin
            if (tcnt_q == 3'd0) begin
              first_d = data_byte_i;
            end
            tcnt_d = tcnt_q + 3'd1;
            mode_d = (tcnt_d >= TAG_NAME_MAX) ? MODE_TAG_SKIP : MODE_TAG_NAME;
          end
        end
        MODE_TAG_SKIP: begin
          if (data_byte_i == CH_GT) begin
            do_ftag = 1'b1;
          end
        end
        MODE_ENTITY: begin
          if (data_byte_i == CH_SEMI) begin
            do_fent = 1'b1;
          end else if (data_byte_i == CH_AMP) begin
            do_fent  = 1'b1;
            do_start = 1'b1;
          end else if (ecnt_q >= ENTITY_MAX) begin
            // overlong entity: close it and treat this byte as plain text
            do_fent = 1'b1;
            do_text = 1'b1;
          end else begin
            if (ecnt_q < 4'd4) begin
              ent_d[ecnt_q[1:0]] = data_byte_i;
            end
            ecnt_d = ecnt_q + 4'd1;
          end
        end
        default: begin
          do_text = 1'b1;
        end
      endcase
    end

    if (do_ftag) begin
      if (lht_d) begin
        l     = res_push(l, KIND_EOL, 8'h00, sty_d);
        lht_d = 1'b0;
        any_d = 1'b1;
      end
      mode_d = MODE_TEXT;
      if (tcnt_d == 3'd0 || clos_d) begin
        sty_d = STYLE_NORMAL;
      end else begin
        t = first_d;
        if (t >= "A" && t <= "Z") begin
          t = t + CH_CASE;
        end
        case (t) inside
          "h": begin
            sty_d = STYLE_TITLE;
            l     = res_push(l, KIND_BLANK, 8'h00, STYLE_NORMAL);
            any_d = 1'b1;
          end
          "a": begin
            sty_d = STYLE_LINK;
          end
          "l", "p", "d": begin
            l     = res_push(l, KIND_BLANK, 8'h00, STYLE_NORMAL);
            any_d = 1'b1;
          end
          "b", "t": begin
          end
          default: begin
            sty_d = STYLE_NORMAL;
          end
        endcase
      end
    end

    if (do_fent) begin
      mode_d = MODE_TEXT;
      ehit   = 1'b1;
      if (ecnt_d == 4'd3 && ent_d[0] == "a" && ent_d[1] == "m" && ent_d[2] == "p") begin
        ech = CH_AMP;
      end else if (ecnt_d == 4'd2 && ent_d[0] == "l" && ent_d[1] == "t") begin
        ech = CH_LT;
      end else if (ecnt_d == 4'd2 && ent_d[0] == "g" && ent_d[1] == "t") begin
        ech = CH_GT;
      end else if (ecnt_d == 4'd4 && ent_d[0] == "q" && ent_d[1] == "u" &&
                   ent_d[2] == "o" && ent_d[3] == "t") begin
        ech = CH_QUOT;
      end else if (ecnt_d == 4'd4 && ent_d[0] == "n" && ent_d[1] == "b" &&
                   ent_d[2] == "s" && ent_d[3] == "p") begin
        ech = CH_SPACE;
      end else if (ecnt_d == 4'd3 && ent_d[0] == "#" && ent_d[1] == "3" &&
                   ent_d[2] == "9") begin
        ech = CH_APOS;
      end else begin
        ehit = 1'b0;
      end
      if (ehit) begin
        l     = res_push(l, KIND_CHAR, ech, STYLE_NORMAL);
        lht_d = 1'b1;
      end
    end

    if (do_text) begin
      mode_d = MODE_TEXT;
      if (data_byte_i == CH_LT) begin
        mode_d  = MODE_TAG_START;
        clos_d  = 1'b0;
        first_d = 8'h00;
        tcnt_d  = 3'd0;
      end else if (data_byte_i == CH_AMP) begin
        do_start = 1'b1;
      end else if (data_byte_i != CH_LF && data_byte_i != CH_CR) begin
        l     = res_push(l, KIND_CHAR, data_byte_i, STYLE_NORMAL);
        lht_d = 1'b1;
      end
    end

    if (do_start) begin
      mode_d = MODE_ENTITY;
      ecnt_d = 4'd0;
      ent_d  = '0;
    end

    if (op_i == OP_END) begin
      if (lht_d) begin
        l     = res_push(l, KIND_EOL, 8'h00, sty_d);
        any_d = 1'b1;
      end
      if (!any_d) begin
        l = res_push(l, KIND_EMPTY, 8'h00, STYLE_NORMAL);
      end
      l = res_push(l, KIND_END, 8'h00, STYLE_NORMAL);
      // drop all scan state for the next document
      mode_d  = MODE_TEXT;
      clos_d  = 1'b0;
      first_d = 8'h00;
      tcnt_d  = 3'd0;
      sty_d   = STYLE_NORMAL;
      lht_d   = 1'b0;
      any_d   = 1'b0;
      ent_d   = '0;
      ecnt_d  = 4'd0;
    end

    res_o = l;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_TEXT;
      clos_q  <= 1'b0;
      first_q <= 8'h00;
      tcnt_q  <= 3'd0;
      sty_q   <= STYLE_NORMAL;
      lht_q   <= 1'b0;
      any_q   <= 1'b0;
      ent_q   <= '0;
      ecnt_q  <= 4'd0;
    end else if (en_i) begin
      mode_q  <= mode_d;
      clos_q  <= clos_d;
      first_q <= first_d;
      tcnt_q  <= tcnt_d;
      sty_q   <= sty_d;
      lht_q   <= lht_d;
      any_q   <= any_d;
      ent_q   <= ent_d;
      ecnt_q  <= ecnt_d;
    end
  end

endmodule
`default_nettype wire

>>> rtl/mtl_rbuf.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mtl_rbuf
// Three-entry result register; loads a whole result list and hands the
// results out one transaction at a time.
// ----------------------------------------------------------------------------
module mtl_rbuf import mtl_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      load_i,
  input  res_list_t      list_i,
  input  wire logic      out_ready_i,
  output logic           out_valid_o,
  output res_t           res_o,
  output logic           free_o
);

  res_t [2:0] r_q, r_d;
  logic [1:0] rem_q, rem_d;
  logic       pop;

  assign out_valid_o = (rem_q != 2'd0);
  assign res_o       = r_q[0];
  assign pop         = out_valid_o && out_ready_i;
  assign free_o      = (rem_q == 2'd0) || (rem_q == 2'd1 && out_ready_i);

  always_comb begin
    r_d   = r_q;
    rem_d = rem_q;
    if (load_i) begin
      r_d   = list_i.r;
      rem_d = list_i.n;
    end else if (pop) begin
      // advance the queue by one entry
      r_d[0] = r_q[1];
      r_d[1] = r_q[2];
      rem_d  = rem_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    r_q <= r_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= 2'd0;
    end else begin
      rem_q <= rem_d;
    end
  end

endmodule
`default_nettype wire

>>> rtl/markup_to_text_lines.sv
`default_nettype none
// ----------------------------------------------------------------------------
// markup_to_text_lines
// Markup document to display text converter: strips tags, decodes entities
// and emits characters, line ends, blank lines and page markers.
// ----------------------------------------------------------------------------
//  Channel | Handshake              | Payload
//  --------+------------------------+------------------------------------------
//  in      | in_valid_i/in_ready_o  | op_i, data_byte_i
//  out     | out_valid_o/out_ready_i| kind_o, text_char_o, line_style_o, last_o
//
//  An accepted byte waits in the input register until the result register is
//  free, is decoded in one pass and its result list (zero to three results)
//  loads the result register. Results leave one per cycle while out_ready_i is high.
//  The input register refills while the last result is still waiting.
//  Reset clears all scan state at once; there is no clearing pass.
// ----------------------------------------------------------------------------
module markup_to_text_lines import mtl_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic       op_i,
  input  wire logic [7:0] data_byte_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [2:0]      kind_o,
  output logic [7:0]      text_char_o,
  output logic [1:0]      line_style_o,
  output logic            last_o
);

  logic       vld_q, vld_d;
  logic       op_q;
  logic [7:0] byte_q;
  logic       buf_free;
  logic       work;
  res_list_t  list;
  res_t       res;

  assign work       = vld_q && buf_free;
  assign in_ready_o = !vld_q || work;

  always_comb begin
    vld_d = vld_q;
    if (in_valid_i && in_ready_o) begin
      vld_d = 1'b1;
    end else if (work) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // hold the payload until the decode takes it
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      op_q   <= op_i;
      byte_q <= data_byte_i;
    end
  end

  mtl_step u_step (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (work),
    .op_i        (op_q),
    .data_byte_i (byte_q),
    .res_o       (list)
  );

  mtl_rbuf u_rbuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (work),
    .list_i      (list),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .res_o       (res),
    .free_o      (buf_free)
  );

  assign kind_o       = res.kind;
  assign text_char_o  = res.ch;
  assign line_style_o = res.style;
  assign last_o       = res.last;

  a_end_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && kind_o == KIND_END) |-> last_o)
    else $error("document end result not marked last");

  a_more_follow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && !last_o) |=> out_valid_o)
    else $error("result list cut short");

  a_char_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && kind_o != KIND_CHAR) |-> (text_char_o == 8'h00))
    else $error("character set on non-character result");

  a_style_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && kind_o != KIND_EOL) |-> (line_style_o == STYLE_NORMAL))
    else $error("style set on result that ends no line");

endmodule
`default_nettype wire

>>> dv/markup_to_text_lines_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// markup_to_text_lines_tb
// Feeds markup documents byte by byte into the converter and checks every
// character, line end, blank line and page marker against a cycle-free
// behavioral predictor. Both channels idle at random and the output side
// holds off once long enough to back the block up into its input.
// ----------------------------------------------------------------------------
module markup_to_text_lines_tb;
  import mtl_pkg::*;

  typedef enum logic [2:0] {
    SCAN_TEXT, SCAN_TAG_OPEN, SCAN_TAG_NAME, SCAN_TAG_SKIP, SCAN_ENTITY
  } scan_e;

  // One pending input transaction; a pause entry carries no byte and makes the
  // sender wait until every expected event has arrived
  typedef struct packed {
    logic       pause;
    logic       op;
    logic [7:0] b;
  } doc_item_t;

  localparam int TAIL_ITEMS = 40;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       op_i = OP_BYTE;
  logic [7:0] data_byte_i = 8'h00;
  logic       out_ready_i = 1'b0;
  logic       in_ready_o;
  logic       out_valid_o;
  logic [2:0] kind_o;
  logic [7:0] text_char_o;
  logic [1:0] line_style_o;
  logic       last_o;

  doc_item_t doc_items_q[$];
  res_t      expected_events_q[$];
  res_t      step_events_q[$];

  // Predictor state
  scan_e      scan_mode;
  logic       tag_is_closing;
  logic [7:0] tag_lead;
  int         tag_len;
  logic [1:0] cur_style;
  logic       line_open;
  logic       page_has_line;
  logic [7:0] ent_buf [4];
  int         ent_len;

  int   errors = 0;
  int   bytes_taken = 0;
  int   doc_len = 0;
  bit   offered = 1'b0;
  int   in_gap = 0;
  int   out_gap = 0;
  int   hold_left = 0;
  bit   hold_done = 1'b0;
  int   in_idle_pct = 20;
  int   out_idle_pct = 20;
  bit   calm;

  markup_to_text_lines DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .op_i         (op_i),
    .data_byte_i  (data_byte_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .kind_o       (kind_o),
    .text_char_o  (text_char_o),
    .line_style_o (line_style_o),
    .last_o       (last_o)
  );

  always #5 clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------
  function automatic void put_event(kind_e k, logic [7:0] ch, logic [1:0] st);
    res_t r;
    r.kind  = k;
    r.ch    = ch;
    r.style = st;
    r.last  = 1'b0;
    if (step_events_q.size() < 3) step_events_q.push_back(r);
  endfunction

  function automatic void add_char(logic [7:0] ch);
    put_event(KIND_CHAR, ch, STYLE_NORMAL);
    line_open = 1'b1;
  endfunction

  function automatic void close_line();
    if (line_open) begin
      put_event(KIND_EOL, 8'h00, cur_style);
      line_open     = 1'b0;
      page_has_line = 1'b1;
    end
  endfunction

  function automatic void add_blank();
    put_event(KIND_BLANK, 8'h00, STYLE_NORMAL);
    page_has_line = 1'b1;
  endfunction

  function automatic void clear_scan();
    scan_mode      = SCAN_TEXT;
    tag_is_closing = 1'b0;
    tag_lead       = 8'h00;
    tag_len        = 0;
    cur_style      = STYLE_NORMAL;
    line_open      = 1'b0;
    page_has_line  = 1'b0;
    ent_buf        = '{default: 8'h00};
    ent_len        = 0;
  endfunction

  function automatic void finish_tag();
    logic [7:0] t;
    t = tag_lead;
    close_line();
    scan_mode = SCAN_TEXT;
    if (tag_len == 0 || tag_is_closing) begin
      cur_style = STYLE_NORMAL;
    end else begin
      if (t >= "A" && t <= "Z") t = t + CH_CASE;
      if (t == "h") begin
        cur_style = STYLE_TITLE;
        add_blank();
      end else if (t == "a") begin
        cur_style = STYLE_LINK;
      end else if (t == "l" || t == "p" || t == "d") begin
        add_blank();
      end else if (t != "b" && t != "t") begin
        cur_style = STYLE_NORMAL;
      end
    end
  endfunction

  function automatic void finish_entity();
    logic [31:0] w;
    w = {ent_buf[0], ent_buf[1], ent_buf[2], ent_buf[3]};
    scan_mode = SCAN_TEXT;
    if (ent_len == 3 && w == {"amp", 8'h00}) add_char(CH_AMP);
    else if (ent_len == 2 && w == {"lt", 16'h0000}) add_char(CH_LT);
    else if (ent_len == 2 && w == {"gt", 16'h0000}) add_char(CH_GT);
    else if (ent_len == 4 && w == "quot") add_char(CH_QUOT);
    else if (ent_len == 4 && w == "nbsp") add_char(CH_SPACE);
    else if (ent_len == 3 && w == {"#39", 8'h00}) add_char(CH_APOS);
  endfunction

  function automatic void open_entity();
    scan_mode = SCAN_ENTITY;
    ent_len   = 0;
    ent_buf   = '{default: 8'h00};
  endfunction

  function automatic void plain_byte(logic [7:0] b);
    if (b == CH_LT) begin
      scan_mode      = SCAN_TAG_OPEN;
      tag_is_closing = 1'b0;
      tag_lead       = 8'h00;
      tag_len        = 0;
    end else if (b == CH_AMP) begin
      open_entity();
    end else if (b != CH_LF && b != CH_CR) begin
      add_char(b);
    end
  endfunction

  function automatic void tag_name_byte(logic [7:0] b);
    if (b == CH_GT) begin
      finish_tag();
    end else if (b == CH_SPACE || b == CH_LF) begin
      scan_mode = SCAN_TAG_SKIP;
    end else begin
      if (tag_len == 0) tag_lead = b;
      tag_len++;
      if (tag_len >= TAG_NAME_MAX) scan_mode = SCAN_TAG_SKIP;
      else scan_mode = SCAN_TAG_NAME;
    end
  endfunction

  // Work out the events of one accepted transaction and queue them
  function automatic void render_step(logic op, logic [7:0] b);
    res_t r;
    step_events_q.delete();
    if (op == OP_END) begin
      if (scan_mode == SCAN_TAG_OPEN || scan_mode == SCAN_TAG_NAME ||
          scan_mode == SCAN_TAG_SKIP) finish_tag();
      else if (scan_mode == SCAN_ENTITY) finish_entity();
      close_line();
      if (!page_has_line) put_event(KIND_EMPTY, 8'h00, STYLE_NORMAL);
      put_event(KIND_END, 8'h00, STYLE_NORMAL);
      clear_scan();
    end else begin
      case (scan_mode)
        SCAN_TAG_OPEN: begin
          if (b == CH_SLASH) begin
            tag_is_closing = 1'b1;
            scan_mode      = SCAN_TAG_NAME;
          end else begin
            tag_name_byte(b);
          end
        end
        SCAN_TAG_NAME: tag_name_byte(b);
        SCAN_TAG_SKIP: if (b == CH_GT) finish_tag();
        SCAN_ENTITY: begin
          if (b == CH_SEMI) begin
            finish_entity();
          end else if (b == CH_AMP) begin
            finish_entity();
            open_entity();
          end else if (ent_len >= ENTITY_MAX) begin
            finish_entity();
            plain_byte(b);
          end else begin
            if (ent_len < 4) ent_buf[ent_len] = b;
            ent_len++;
          end
        end
        default: begin
          scan_mode = SCAN_TEXT;
          plain_byte(b);
        end
      endcase
    end
    if (step_events_q.size() > 0) begin
      r = step_events_q.pop_back();
      r.last = 1'b1;
      step_events_q.push_back(r);
    end
    foreach (step_events_q[i]) expected_events_q.push_back(step_events_q[i]);
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus building
  // --------------------------------------------------------------------------
  function automatic void push_byte(logic [7:0] b);
    doc_item_t it;
    it.pause = 1'b0;
    it.op    = OP_BYTE;
    it.b     = b;
    doc_items_q.push_back(it);
    doc_len++;
  endfunction

  function automatic void push_end();
    doc_item_t it;
    it.pause = 1'b0;
    it.op    = OP_END;
    it.b     = 8'($urandom_range(0, 255));
    doc_items_q.push_back(it);
    doc_len++;
  endfunction

  function automatic void push_pause();
    doc_item_t it;
    it.pause = 1'b1;
    it.op    = OP_BYTE;
    it.b     = 8'h00;
    doc_items_q.push_back(it);
  endfunction

  function automatic void push_str(string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i]);
  endfunction

  function automatic logic [7:0] pick_from(string s);
    return s[$urandom_range(0, s.len() - 1)];
  endfunction

  function automatic logic [7:0] text_like();
    int sel;
    sel = $urandom_range(0, 19);
    if (sel == 0) return CH_CR;
    if (sel == 1) return CH_LF;
    if (sel == 2) return 8'h00;
    if (sel == 3) return 8'($urandom_range(128, 255));
    if (sel == 4) return CH_SPACE;
    return pick_from("abcdefghijklmnopqrstuvwxyzABCXYZ0123456789.,!?");
  endfunction

  function automatic void add_tag();
    int n;
    push_byte(CH_LT);
    if ($urandom_range(0, 3) == 0) push_byte(CH_SLASH);
    n = $urandom_range(0, 9) == 0 ? $urandom_range(7, 10) : $urandom_range(0, 4);
    for (int i = 0; i < n; i++) begin
      if (i == 0 && $urandom_range(0, 7) != 0) push_byte(pick_from("hHaAlLpPdDbBtTxzq"));
      else if ($urandom_range(0, 11) == 0) push_byte(pick_from("<\r/&"));
      else if (i == 0) push_byte(8'($urandom_range(0, 255)));
      else push_byte(pick_from("123456abcdefrm"));
    end
    // attributes after a space or LF, skipped up to the closing bracket
    if ($urandom_range(0, 2) == 0) begin
      push_byte($urandom_range(0, 1) ? CH_SPACE : CH_LF);
      n = $urandom_range(0, 6);
      for (int i = 0; i < n; i++) push_byte(pick_from("href=\"x\" <&;/ \n"));
    end
    if ($urandom_range(0, 9) != 0) push_byte(CH_GT);
  endfunction

  function automatic void add_entity();
    int n;
    push_byte(CH_AMP);
    case ($urandom_range(0, 9))
      0: push_str("amp");
      1: push_str("lt");
      2: push_str("gt");
      3: push_str("quot");
      4: push_str("nbsp");
      5: push_str("#39");
      6: begin
        if ($urandom_range(0, 1) != 0) push_str("nbspx");
        else push_str("am");
      end
      7: begin
        n = $urandom_range(12, 17);
        for (int i = 0; i < n; i++) push_byte(pick_from("abcdefgh#0123"));
      end
      default: begin
        n = $urandom_range(0, 5);
        for (int i = 0; i < n; i++) push_byte(text_like());
      end
    endcase
    case ($urandom_range(0, 9))
      0, 1: ;
      2: push_byte(CH_AMP);
      default: push_byte(CH_SEMI);
    endcase
  endfunction

  function automatic void add_document();
    int n;
    if ($urandom_range(0, 9) == 0) begin
      // noise document
      n = $urandom_range(1, 20);
      for (int i = 0; i < n; i++) push_byte(8'($urandom_range(0, 255)));
    end else begin
      n = $urandom_range(0, 12);
      for (int i = 0; i < n; i++) begin
        case ($urandom_range(0, 9))
          0, 1, 2: add_tag();
          3, 4:    add_entity();
          5:       push_byte(8'($urandom_range(0, 255)));
          default: repeat ($urandom_range(1, 4)) push_byte(text_like());
        endcase
      end
    end
    push_end();
  endfunction

  // --------------------------------------------------------------------------
  // Sender
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) begin
      render_step(op_i, data_byte_i);
      offered = 1'b0;
      bytes_taken++;
      if (bytes_taken % 40 == 0) begin
        case ($urandom_range(0, 2))
          0: in_idle_pct = 0;
          1: in_idle_pct = 15;
          default: in_idle_pct = 40;
        endcase
        case ($urandom_range(0, 2))
          0: out_idle_pct = 0;
          1: out_idle_pct = 15;
          default: out_idle_pct = 40;
        endcase
      end
      if (!calm && $urandom_range(0, 99) < in_idle_pct) in_gap = $urandom_range(1, 5);
    end
  end

  always @(negedge clk_i) begin
    doc_item_t it;
    calm = doc_items_q.size() < TAIL_ITEMS;
    if (rst_ni && !offered) begin
      if (in_gap > 0) begin
        in_gap--;
        in_valid_i <= 1'b0;
      end else if (doc_items_q.size() > 0 && doc_items_q[0].pause) begin
        // hold until the output side has caught up completely
        if (expected_events_q.size() == 0) void'(doc_items_q.pop_front());
        in_valid_i <= 1'b0;
      end else if (doc_items_q.size() > 0) begin
        it = doc_items_q.pop_front();
        in_valid_i  <= 1'b1;
        op_i        <= it.op;
        data_byte_i <= it.b;
        offered = 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver
  // --------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!hold_done && bytes_taken >= 150) begin
        hold_done = 1'b1;
        hold_left = 250;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (out_gap > 0) begin
        out_gap--;
        out_ready_i <= 1'b0;
      end else if (!calm && $urandom_range(0, 99) < out_idle_pct) begin
        out_gap = $urandom_range(0, 4);
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_events_q.size() == 0) begin
        $display("%0t: unexpected event kind %0d char %02h style %0d last %0d",
                 $time, kind_o, text_char_o, line_style_o, last_o);
        errors++;
      end else begin
        want = expected_events_q.pop_front();
        if (kind_o != want.kind || text_char_o != want.ch ||
            line_style_o != want.style || last_o != want.last) begin
          $display("%0t: event mismatch expected kind %0d char %02h style %0d last %0d",
                   $time, want.kind, want.ch, want.style, want.last);
          $display("%0t:                   actual kind %0d char %02h style %0d last %0d",
                   $time, kind_o, text_char_o, line_style_o, last_o);
          errors++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    int docs;
    clear_scan();
    // empty document
    push_end();
    // title tag, byte zero, high byte, entity left open at the end
    push_str("<H>");
    push_byte(8'h00);
    push_byte(8'hFF);
    push_str("&lt");
    push_end();
    // closing tag with CR in its name, left open at the end
    push_str("z</b");
    push_byte(CH_CR);
    push_byte(CH_LF);
    push_end();
    // entity break and a decoded apostrophe
    push_str("&quot&#39;");
    push_end();
    push_pause();
    docs = 0;
    while (doc_len < 480) begin
      add_document();
      docs++;
      if (docs % 6 == 0) push_pause();
    end

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (doc_items_q.size() != 0 || offered || expected_events_q.size() != 0)
      @(posedge clk_i);
    repeat (16) @(posedge clk_i);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

>>> markup_to_text_lines.f
rtl/mtl_pkg.sv
rtl/mtl_step.sv
rtl/mtl_rbuf.sv
rtl/markup_to_text_lines.sv
dv/markup_to_text_lines_tb.sv
